[src/sti_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants for the sorted table
// Table geometry, field widths, item and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sti_pkg;

  // Table geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Channel field widths
  localparam int KIND_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DISPATCH,
    OP_INS_READ,
    OP_SHIFT,
    OP_STOP,
    OP_PUT,
    OP_SRCH_READ,
    OP_FOUND,
    OP_LO_UP,
    OP_HI_DOWN,
    OP_READ_DATA,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
  } sti_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  empty;
    logic  beyond;
    logic  rd_lt;
    logic  rd_eq;
    logic  ptr_zero;
    logic  srch_live;
    logic  out_free;
  } sti_sts_t;

endpackage
`default_nettype wire

[src/sti_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sti_ifs: item and result channels of the sorted table
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface sti_item_if import sti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, kind, value, index, input ready);
  modport sink   (input valid, kind, value, index, output ready);
endinterface

interface sti_result_if import sti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] data;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, status, position, data, count, input ready);
  modport sink   (input valid, status, position, data, count, output ready);
endinterface
`default_nettype wire

[src/sorted_table_insert_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_insert_search: ascending table with insert, search, read, clear
// Keeps up to DEPTH signed values sorted; insert shifts larger and equal entries up,
// search is a binary search, read returns one entry, clear empties the table.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                         transfer when
//   -------  ---  ------------------------------  -----------------------
//   item     in   kind, value, index              item.valid & item.ready
//   result   out  status, position, data, count   result.valid & result.ready
//
// Steps from the transfer in to the edge that raises result.valid:
//   insert: walks down from the top entry, moving each entry not smaller
//           than the value up, until a smaller entry or the bottom; each
//           move is a RAM read then a write. Full table: no walk.
//   search: a RAM read and a compare per probe; at most log2(DEPTH) + 1
//           probes. read: one RAM read. clear, read beyond count: no RAM read.
// Ready returns with the result.
// Reset clears the count and the result valid flag; the RAM is not cleared.
// A stalled result holds in its register; the next item is taken meanwhile
// and waits at the end of its work until the register frees.
// ----------------------------------------------------------------------------
module sorted_table_insert_search import sti_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  sti_item_if.sink      item,
  sti_result_if.source  result
);

  sti_cmd_t cmd;
  sti_sts_t sts;
  logic     ready;

  // Sequencer: decodes the item kind and paces every step
  sti_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Take an item only between items; ready drops for the whole operation
  assign item.ready = ready;

  // Datapath: table RAM, count, pointers and the result register
  sti_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item_kind    (item.kind),
    .item_value   (item.value),
    .item_index   (item.index),
    .res_ready    (result.ready),
    .res_valid    (result.valid),
    .res_status   (result.status),
    .res_position (result.position),
    .res_data     (result.data),
    .res_count    (result.count)
  );

endmodule
`default_nettype wire

[src/sti_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sti_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sti_ram #(
  parameter int DATA_W = 32,
  parameter int WORDS  = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(WORDS)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(WORDS)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/sti_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sti_ctrl: sequencer for the sorted table
// Decodes the item kind and steps the datapath through insert shifting,
// binary search probes, reads and the result transfer.
// ----------------------------------------------------------------------------
module sti_ctrl import sti_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire sti_sts_t sts,
  output sti_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CMP,
    S_PUT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_READ_DATA,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.load   = item_valid && item_ready;
    cmd.op     = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.op = OP_DISPATCH;
        unique case (sts.kind)
          KIND_INSERT: begin
            priority if (sts.full) begin
              state_next = S_FINISH;
            end else if (sts.empty) begin
              state_next = S_PUT;
            end else begin
              state_next = S_INS_RD;
            end
          end
          KIND_SEARCH: state_next = S_SRCH_RD;
          KIND_READ:   state_next = sts.beyond ? S_FINISH : S_READ_DATA;
          KIND_CLEAR:  state_next = S_FINISH;
        endcase
      end
      S_INS_RD: begin
        cmd.op     = OP_INS_READ;
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (sts.rd_lt) begin
          cmd.op     = OP_STOP;
          state_next = S_PUT;
        end else begin
          cmd.op     = OP_SHIFT;
          state_next = sts.ptr_zero ? S_PUT : S_INS_RD;
        end
      end
      S_PUT: begin
        cmd.op     = OP_PUT;
        state_next = S_FINISH;
      end
      S_SRCH_RD: begin
        cmd.op     = OP_SRCH_READ;
        state_next = sts.srch_live ? S_SRCH_CMP : S_FINISH;
      end
      S_SRCH_CMP: begin
        priority if (sts.rd_eq) begin
          cmd.op     = OP_FOUND;
          state_next = S_FINISH;
        end else if (sts.rd_lt) begin
          cmd.op     = OP_LO_UP;
          state_next = S_SRCH_RD;
        end else begin
          cmd.op     = OP_HI_DOWN;
          state_next = S_SRCH_RD;
        end
      end
      S_READ_DATA: begin
        cmd.op     = OP_READ_DATA;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      item_ready <= 1'b0;
    end else begin
      state      <= state_next;
      item_ready <= (state_next == S_IDLE);
    end
  end

endmodule
`default_nettype wire

[src/sti_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sti_dp: datapath of the sorted table
// Holds the table RAM, entry count, walk pointer, search bounds and the
// result register; acts on one command from the sequencer per cycle.
// ----------------------------------------------------------------------------
module sti_dp import sti_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sti_cmd_t                  cmd,
  output sti_sts_t                       sts,
  input  wire logic [KIND_W-1:0]         item_kind,
  input  wire logic signed [VALUE_W-1:0] item_value,
  input  wire logic [INDEX_W-1:0]        item_index,
  input  wire logic                      res_ready,
  output logic                           res_valid,
  output logic [STATUS_W-1:0]            res_status,
  output logic [POS_W-1:0]               res_position,
  output logic signed [VALUE_W-1:0]      res_data,
  output logic [COUNT_W-1:0]             res_count
);

  kind_e                  kind_q;
  logic [DATA_WIDTH-1:0]  val_q;
  logic [INDEX_W-1:0]     idx_q;
  logic [CNT_W-1:0]       count;
  logic [ADDR_W-1:0]      ptr;
  logic [ADDR_W-1:0]      pos_q;
  status_e                stat_q;
  logic [VALUE_W-1:0]     data_q;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi_ex;    // high bound plus one

  logic [CNT_W:0]         mid_sum;
  logic [ADDR_W-1:0]      mid;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [DATA_WIDTH-1:0]  wdata;
  logic [ADDR_W-1:0]      raddr;
  logic [DATA_WIDTH-1:0]  rdata;

  assign mid_sum = {1'b0, lo} + {1'b0, hi_ex} - (CNT_W + 1)'(1);
  assign mid     = ADDR_W'(mid_sum >> 1);

  always_comb begin
    unique case (cmd.op)
      OP_DISPATCH:  raddr = ADDR_W'(idx_q);
      OP_SRCH_READ: raddr = mid;
      default:      raddr = ptr;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wdata = val_q;
    if (cmd.op == OP_SHIFT) begin
      we    = 1'b1;
      waddr = ptr + ADDR_W'(1);
      wdata = rdata;
    end else if (cmd.op == OP_PUT) begin
      we    = 1'b1;
    end
  end

  sti_ram #(
    .DATA_W (DATA_WIDTH),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.kind      = kind_q;
    sts.full      = (count == CNT_W'(DEPTH));
    sts.empty     = (count == '0);
    sts.beyond    = (32'(idx_q) >= 32'(count));
    sts.rd_lt     = ($signed(rdata) < $signed(val_q));
    sts.rd_eq     = (rdata == val_q);
    sts.ptr_zero  = (ptr == '0);
    sts.srch_live = (lo < hi_ex);
    sts.out_free  = !res_valid || res_ready;
  end

  // Item capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind_e'(item_kind);
      val_q  <= DATA_WIDTH'($signed(item_value));
      idx_q  <= item_index;
    end
    unique case (cmd.op)
      OP_DISPATCH: begin
        pos_q  <= '0;
        data_q <= '0;
        ptr    <= ADDR_W'(count - CNT_W'(1));
        lo     <= '0;
        hi_ex  <= count;
        unique case (kind_q)
          KIND_INSERT: stat_q <= sts.full ? ST_FULL : ST_OK;
          KIND_SEARCH: stat_q <= ST_NOT_FOUND;
          KIND_READ:   stat_q <= sts.beyond ? ST_BEYOND : ST_OK;
          KIND_CLEAR:  stat_q <= ST_OK;
        endcase
      end
      OP_SHIFT:     ptr    <= ptr - ADDR_W'(1);
      OP_STOP:      pos_q  <= ptr + ADDR_W'(1);
      OP_FOUND: begin
        stat_q <= ST_OK;
        pos_q  <= mid;
      end
      OP_LO_UP:     lo     <= CNT_W'(mid) + CNT_W'(1);
      OP_HI_DOWN:   hi_ex  <= CNT_W'(mid);
      OP_READ_DATA: data_q <= VALUE_W'($signed(rdata));
      default: ;
    endcase
  end

  // Entry count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_PUT) begin
        count <= count + CNT_W'(1);
      end else if (cmd.op == OP_DISPATCH && kind_q == KIND_CLEAR) begin
        count <= '0;
      end
      if (cmd.op == OP_EMIT) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      res_status   <= stat_q;
      res_position <= POS_W'(pos_q);
      res_data     <= data_q;
      res_count    <= COUNT_W'(count);
    end
  end

endmodule
`default_nettype wire

[src/sti_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sti_checker: port-level checks for the sorted table
// Watches the item and result channels and flags impossible results.
// ----------------------------------------------------------------------------
module sti_checker import sti_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      item_valid,
  input wire logic                      item_ready,
  input wire logic                      res_valid,
  input wire logic                      res_ready,
  input wire logic [STATUS_W-1:0]       res_status,
  input wire logic signed [VALUE_W-1:0] res_data,
  input wire logic [COUNT_W-1:0]        res_count
);

  // A stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // One item at a time: no second transfer right after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while busy");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 32'(res_count) <= DEPTH)
    else $error("count above table depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_FULL |-> 32'(res_count) == DEPTH)
    else $error("table full reported below depth");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |-> res_data == '0)
    else $error("data set on a failed item");

endmodule

bind sorted_table_insert_search sti_checker u_sti_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_status (result.status),
  .res_data   (result.data),
  .res_count  (result.count)
);
`default_nettype wire
